// ----- sv/matmul_tile_read_address_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tile read address generator
// Concurrent checks clocked on clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef MATMUL_TILE_READ_ADDRESS_GENERATOR_MACROS_SVH
`define MATMUL_TILE_READ_ADDRESS_GENERATOR_MACROS_SVH

// Checked only while the block is out of reset.
`define MTRAG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define MTRAG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/mtrag_pkg.sv -----
// ----------------------------------------------------------------------------
// mtrag_pkg
// Shared types and constants of the tile read address generator.
// ----------------------------------------------------------------------------
package mtrag_pkg;

	localparam int unsigned DATA_W            = 32;
	localparam int unsigned ADDR_W            = 4;
	localparam int unsigned TILE_ELEMENTS_DEF = 1024;
	localparam int unsigned DIV_W             = 32;

	// Command codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_COLS  = 2'd2;
	localparam logic [1:0] REG_BCAST = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [31:0] start_tile;
		logic [23:0] tile_count;
	} cmd_t;

	typedef struct packed {
		logic [31:0] a_byte_offset;
		logic [31:0] b_byte_offset;
		logic        last_of_tile;
		logic        last_of_all;
		logic        exhausted;
	} pair_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ----- sv/mtrag_div.sv -----
// ----------------------------------------------------------------------------
// mtrag_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtrag_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mtrag_pkg::div_req_t req,
	output mtrag_pkg::div_rsp_t rsp
);

	localparam int unsigned W     = mtrag_pkg::DIV_W;
	localparam int unsigned CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvsr_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       fits;

	// The dividend shifts out of the quotient register as quotient bits shift in.
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- sv/matmul_tile_read_address_generator.sv -----
// ----------------------------------------------------------------------------
// matmul_tile_read_address_generator
// Operand tile read offsets for a tiled batched matrix multiply.
// ----------------------------------------------------------------------------
// A step word's pair is valid from the cycle after the word is accepted.
// A start word runs two passes through the shared divider, followed by three
// passes through the shared multiplier and a load.
// After a register write, and after reset, the sequencer refreshes the derived products.
// Reset is asynchronous, active low; it sets the registers to 1, 1, 1 and 0.
// ----------------------------------------------------------------------------
module matmul_tile_read_address_generator #(
	parameter int unsigned TILE_ELEMENTS = mtrag_pkg::TILE_ELEMENTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  mtrag_pkg::cmd_t                  cmd,
	output logic                             pair_valid,
	input  logic                             pair_ready,
	output mtrag_pkg::pair_t                 pair,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mtrag_pkg::ADDR_W-1:0]     paddr,
	input  logic [mtrag_pkg::DATA_W-1:0]     pwdata,
	output logic [mtrag_pkg::DATA_W-1:0]     prdata,
	output logic                             pready
);

	`include "matmul_tile_read_address_generator_macros.svh"

	localparam logic [31:0] TE = 32'(TILE_ELEMENTS);

	typedef enum logic [14:0] {
		S_IDLE    = 15'b000000000000001,
		S_C_MTNT  = 15'b000000000000010,
		S_C_KTNT  = 15'b000000000000100,
		S_C_KTE   = 15'b000000000001000,
		S_C_NTE   = 15'b000000000010000,
		S_C_KTNTE = 15'b000000000100000,
		S_C_AD    = 15'b000000001000000,
		S_C_D2    = 15'b000000010000000,
		S_C_D1    = 15'b000000100000000,
		S_DIV1    = 15'b000001000000000,
		S_DIV2    = 15'b000010000000000,
		S_MULA    = 15'b000100000000000,
		S_MULB1   = 15'b001000000000000,
		S_MULB2   = 15'b010000000000000,
		S_BFIN    = 15'b100000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] rows_q;
	logic [15:0] inner_q;
	logic [15:0] cols_q;
	logic        bcast_q;

	// Products derived from the registers.
	logic [31:0] mtnt_q;
	logic [31:0] ktnt_q;
	logic [31:0] kte_q;
	logic [31:0] nte_q;
	logic [31:0] ktnte_q;
	logic [31:0] ad_q;
	logic [31:0] d2_q;
	logic [31:0] d1_q;

	// Run state.
	logic [31:0] a_pos_q;
	logic [31:0] b_pos_q;
	logic [15:0] icnt_q;
	logic [15:0] ccnt_q;
	logic [31:0] mtc_q;
	logic [23:0] left_q;
	logic [31:0] pos_q;
	logic [31:0] q1_q;
	logic [31:0] q2_q;

	logic             out_valid_q;
	mtrag_pkg::pair_t out_q;

	// Shared multiplier.
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_p_q;

	mtrag_pkg::div_req_t div_req;
	mtrag_pkg::div_rsp_t div_rsp;

	logic [15:0] mt_eff;
	logic [15:0] kt_eff;
	logic [15:0] nt_eff;
	logic        cfg_wr;
	logic        cmd_acc;
	logic        is_start;
	logic        is_step;
	logic        tile_end;
	logic        col_end;
	logic [32:0] mtc_inc;
	logic        mat_end;
	logic [31:0] a_delta;
	logic [31:0] b_delta;

	assign mt_eff = (rows_q  == 16'd0) ? 16'd1 : rows_q;
	assign kt_eff = (inner_q == 16'd0) ? 16'd1 : inner_q;
	assign nt_eff = (cols_q  == 16'd0) ? 16'd1 : cols_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			mtrag_pkg::REG_ROWS:  prdata = {16'd0, rows_q};
			mtrag_pkg::REG_INNER: prdata = {16'd0, inner_q};
			mtrag_pkg::REG_COLS:  prdata = {16'd0, cols_q};
			mtrag_pkg::REG_BCAST: prdata = {31'd0, bcast_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= 16'd1;
			inner_q <= 16'd1;
			cols_q  <= 16'd1;
			bcast_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mtrag_pkg::REG_ROWS:  rows_q  <= pwdata[15:0];
				mtrag_pkg::REG_INNER: inner_q <= pwdata[15:0];
				mtrag_pkg::REG_COLS:  cols_q  <= pwdata[15:0];
				mtrag_pkg::REG_BCAST: bcast_q <= pwdata[0];
				default:              ;
			endcase
		end
	end

	assign cmd_ready = (state_q == S_IDLE) && (!out_valid_q || pair_ready);
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign is_start  = cmd_acc && (cmd.opcode == mtrag_pkg::OP_START);
	assign is_step   = cmd_acc && (cmd.opcode == mtrag_pkg::OP_STEP);

	// Step decisions.
	assign tile_end = ({1'b0, icnt_q} + 17'd1) >= {1'b0, kt_eff};
	assign col_end  = ({1'b0, ccnt_q} + 17'd1) >= {1'b0, nt_eff};
	assign mtc_inc  = {1'b0, mtc_q} + 33'd1;
	assign mat_end  = mtc_inc >= {1'b0, mtnt_q};

	// The position updates fold into one precomputed delta per case.
	assign a_delta = (tile_end && !col_end) ? ad_q : TE;

	always_comb begin
		if (!tile_end) begin
			b_delta = nte_q;
		end else if (!col_end) begin
			b_delta = d1_q;
		end else if (mat_end && !bcast_q) begin
			b_delta = TE;
		end else begin
			b_delta = d2_q;
		end
	end

	// Divider requests come from the start word and then from the first division.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = cmd.start_tile;
		div_req.divisor  = {16'd0, nt_eff};
		if (is_start) begin
			div_req.start = 1'b1;
		end else if ((state_q == S_DIV1) && div_rsp.done) begin
			div_req.start    = 1'b1;
			div_req.dividend = pos_q;
			div_req.divisor  = mtnt_q;
		end
	end

	mtrag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		mul_a = {16'd0, mt_eff};
		mul_b = {16'd0, nt_eff};
		unique case (state_q)
			S_C_KTNT: begin
				mul_a = {16'd0, kt_eff};
				mul_b = {16'd0, nt_eff};
			end
			S_C_KTE: begin
				mul_a = {16'd0, kt_eff};
				mul_b = TE;
			end
			S_C_NTE: begin
				mul_a = {16'd0, nt_eff};
				mul_b = TE;
			end
			S_C_KTNTE: begin
				mul_a = ktnt_q;
				mul_b = TE;
			end
			S_MULA: begin
				mul_a = q1_q;
				mul_b = kte_q;
			end
			S_MULB1: begin
				mul_a = q2_q;
				mul_b = ktnt_q;
			end
			S_MULB2: begin
				mul_a = {16'd0, ccnt_q} + (bcast_q ? 32'd0 : mul_p_q);
				mul_b = TE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_C_MTNT;
		end else if (cfg_wr) begin
			state_q <= S_C_MTNT;
		end else begin
			unique case (state_q)
				S_IDLE:    state_q <= is_start ? S_DIV1 : S_IDLE;
				S_C_MTNT:  state_q <= S_C_KTNT;
				S_C_KTNT:  state_q <= S_C_KTE;
				S_C_KTE:   state_q <= S_C_NTE;
				S_C_NTE:   state_q <= S_C_KTNTE;
				S_C_KTNTE: state_q <= S_C_AD;
				S_C_AD:    state_q <= S_C_D2;
				S_C_D2:    state_q <= S_C_D1;
				S_C_D1:    state_q <= S_IDLE;
				S_DIV1:    state_q <= div_rsp.done ? S_DIV2 : S_DIV1;
				S_DIV2:    state_q <= div_rsp.done ? S_MULA : S_DIV2;
				S_MULA:    state_q <= S_MULB1;
				S_MULB1:   state_q <= S_MULB2;
				S_MULB2:   state_q <= S_BFIN;
				S_BFIN:    state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// Derived products; each multiply result passes through the product register mul_p_q before it lands here.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_C_KTNT:  mtnt_q  <= mul_p_q;
			S_C_KTE:   ktnt_q  <= mul_p_q;
			S_C_NTE:   kte_q   <= mul_p_q;
			S_C_KTNTE: nte_q   <= mul_p_q;
			S_C_AD: begin
				ktnte_q <= mul_p_q;
				ad_q    <= TE - kte_q;
			end
			S_C_D2:    d2_q    <= TE - ktnte_q;
			S_C_D1:    d1_q    <= d2_q + nte_q;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_pos_q <= '0;
			b_pos_q <= '0;
			icnt_q  <= '0;
			ccnt_q  <= '0;
			mtc_q   <= '0;
			left_q  <= '0;
		end else begin
			if (is_start) begin
				icnt_q <= '0;
				left_q <= cmd.tile_count;
			end else if (is_step && (left_q != 24'd0)) begin
				a_pos_q <= a_pos_q + a_delta;
				b_pos_q <= b_pos_q + b_delta;
				if (tile_end) begin
					icnt_q <= '0;
					left_q <= left_q - 24'd1;
					mtc_q  <= mat_end ? 32'd0 : mtc_inc[31:0];
					ccnt_q <= col_end ? 16'd0 : ccnt_q + 16'd1;
				end else begin
					icnt_q <= icnt_q + 16'd1;
				end
			end
			if ((state_q == S_DIV1) && div_rsp.done) begin
				ccnt_q <= div_rsp.remainder[15:0];
			end
			if ((state_q == S_DIV2) && div_rsp.done) begin
				mtc_q <= div_rsp.remainder;
			end
			if (state_q == S_MULB1) begin
				a_pos_q <= mul_p_q;
			end
			if (state_q == S_BFIN) begin
				b_pos_q <= mul_p_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_start) begin
			pos_q <= cmd.start_tile;
		end
		if ((state_q == S_DIV1) && div_rsp.done) begin
			q1_q <= div_rsp.quotient;
		end
		if ((state_q == S_DIV2) && div_rsp.done) begin
			q2_q <= div_rsp.quotient;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_step) begin
			out_valid_q <= 1'b1;
		end else if (pair_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_step) begin
			if (left_q == 24'd0) begin
				out_q.a_byte_offset <= '0;
				out_q.b_byte_offset <= '0;
				out_q.last_of_tile  <= 1'b0;
				out_q.last_of_all   <= 1'b0;
				out_q.exhausted     <= 1'b1;
			end else begin
				out_q.a_byte_offset <= {a_pos_q[30:0], 1'b0};
				out_q.b_byte_offset <= {b_pos_q[30:0], 1'b0};
				out_q.last_of_tile  <= tile_end;
				out_q.last_of_all   <= tile_end && (left_q == 24'd1);
				out_q.exhausted     <= 1'b0;
			end
		end
	end

	assign pair_valid = out_valid_q;
	assign pair       = out_q;

	`MTRAG_ASSERT(a_exhausted_zero, (pair_valid && pair.exhausted) |-> ((pair.a_byte_offset == 32'd0) && (pair.b_byte_offset == 32'd0) && !pair.last_of_tile), "exhausted word carries an offset or a flag")
	`MTRAG_ASSERT(a_last_all_tile, (pair_valid && pair.last_of_all) |-> pair.last_of_tile, "last of run without last of tile")
	`MTRAG_ASSERT(a_start_no_word, (is_start && !pair_ready) |=> (state_q == S_DIV1) && (pair_valid == $past(pair_valid)), "start word changed the output")
	`MTRAG_ASSERT(a_div_done_state, div_rsp.done |-> ((state_q == S_DIV1) || (state_q == S_DIV2)), "division finished outside a division state")
	`MTRAG_ASSERT_ALWAYS(a_ready_idle, cmd_ready |-> (state_q == S_IDLE), "command accepted while the sequencer is busy")

endmodule

// ----- verif/matmul_tile_read_address_generator_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for matmul_tile_read_address_generator
// Drives start and step words through the command channel and predicts every
// A/B read pair, including exhaustion, tile, column, matrix and batch wraps.
// Grid sizes are reprogrammed between phases, so a run continues under new
// settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module matmul_tile_read_address_generator_tb;

	localparam logic [31:0] ELEMS_PER_TILE = mtrag_pkg::TILE_ELEMENTS_DEF;
	localparam int unsigned REPORT_LIMIT   = 10;
	localparam int unsigned SETTLE_CYCLES  = 120;
	localparam int unsigned PHASES         = 12;
	localparam int unsigned PHASE_WORDS    = 140;

	// Receiver stall patterns.
	localparam int unsigned RX_ALWAYS   = 0;
	localparam int unsigned RX_ONE_IN_4 = 1;
	localparam int unsigned RX_COIN     = 2;
	localparam int unsigned RX_RUNS     = 3;

	// Kinds of grid settings.
	localparam int unsigned CFG_LARGEST = 0;
	localparam int unsigned CFG_ZERO    = 1;
	localparam int unsigned CFG_TINY    = 2;
	localparam int unsigned CFG_WIDE    = 3;
	localparam int unsigned CFG_RAW     = 4;
	localparam int unsigned CFG_MIXED   = 5;

	class read_pair_scoreboard;
		bit [15:0] rows;
		bit [15:0] inner;
		bit [15:0] cols;
		bit        bcast;
		bit [31:0] a_pos;
		bit [31:0] b_pos;
		bit [15:0] inner_cnt;
		bit [15:0] col_cnt;
		bit [31:0] mat_cnt;
		bit [23:0] left;
		mtrag_pkg::pair_t expected_pairs[$];
		int unsigned failures;

		function new();
			rows      = 16'd1;
			inner     = 16'd1;
			cols      = 16'd1;
			bcast     = 1'b0;
			a_pos     = '0;
			b_pos     = '0;
			inner_cnt = '0;
			col_cnt   = '0;
			mat_cnt   = '0;
			left      = '0;
			failures  = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] value);
			case (idx)
				mtrag_pkg::REG_ROWS:  rows  = value[15:0];
				mtrag_pkg::REG_INNER: inner = value[15:0];
				mtrag_pkg::REG_COLS:  cols  = value[15:0];
				mtrag_pkg::REG_BCAST: bcast = value[0];
				default: ;
			endcase
		endfunction

		function int unsigned inner_tiles();
			return (inner == 16'd0) ? 1 : inner;
		endfunction

		function int unsigned outstanding();
			return expected_pairs.size();
		endfunction

		// Applies one accepted command word to the predicted state.
		function void note_word(mtrag_pkg::cmd_t w);
			bit [31:0] mt;
			bit [31:0] kt;
			bit [31:0] nt;
			bit [31:0] mtnt;
			bit [31:0] ktnt;
			bit [31:0] pos;
			bit [31:0] bpos;
			bit        tile_end;
			bit        matrix_end;
			mtrag_pkg::pair_t p;
			mt   = (rows  == 16'd0) ? 32'd1 : {16'd0, rows};
			kt   = (inner == 16'd0) ? 32'd1 : {16'd0, inner};
			nt   = (cols  == 16'd0) ? 32'd1 : {16'd0, cols};
			mtnt = mt * nt;
			ktnt = kt * nt;
			if (w.opcode == mtrag_pkg::OP_START) begin
				pos     = w.start_tile;
				a_pos   = (pos / nt) * kt * ELEMS_PER_TILE;
				mat_cnt = pos % mtnt;
				col_cnt = 16'(pos % nt);
				bpos    = {16'd0, col_cnt};
				if (!bcast)
					bpos = bpos + (pos / mtnt) * ktnt;
				b_pos     = bpos * ELEMS_PER_TILE;
				inner_cnt = '0;
				left      = w.tile_count;
				return;
			end
			p = '0;
			if (left == 24'd0) begin
				p.exhausted = 1'b1;
				expected_pairs.push_back(p);
				return;
			end
			tile_end        = ({16'd0, inner_cnt} + 32'd1) >= kt;
			p.a_byte_offset = a_pos << 1;
			p.b_byte_offset = b_pos << 1;
			p.last_of_tile  = tile_end;
			p.last_of_all   = tile_end && (left == 24'd1);
			expected_pairs.push_back(p);
			a_pos = a_pos + ELEMS_PER_TILE;
			b_pos = b_pos + nt * ELEMS_PER_TILE;
			if (!tile_end) begin
				inner_cnt = inner_cnt + 16'd1;
				return;
			end
			inner_cnt = '0;
			left      = left - 24'd1;
			b_pos     = b_pos - ktnt * ELEMS_PER_TILE + ELEMS_PER_TILE;
			if (({16'd0, col_cnt} + 32'd1) >= nt) begin
				// End of a column row: rewind B to the first column.
				matrix_end = (mat_cnt + 32'd1) >= mtnt;
				col_cnt    = '0;
				b_pos      = b_pos - nt * ELEMS_PER_TILE;
				if (matrix_end) begin
					mat_cnt = '0;
					if (!bcast)
						b_pos = b_pos + ktnt * ELEMS_PER_TILE;
				end else begin
					mat_cnt = mat_cnt + 32'd1;
				end
			end else begin
				// Same row of output tiles: A goes back to the row's first inner tile.
				col_cnt = col_cnt + 16'd1;
				mat_cnt = ((mat_cnt + 32'd1) >= mtnt) ? 32'd0 : mat_cnt + 32'd1;
				a_pos   = a_pos - kt * ELEMS_PER_TILE;
			end
		endfunction

		function void check_pair(mtrag_pkg::pair_t got);
			mtrag_pkg::pair_t exp;
			string bad;
			if (expected_pairs.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: pair with nothing expected: a %h b %h lt %b la %b ex %b",
						$realtime, got.a_byte_offset, got.b_byte_offset, got.last_of_tile,
						got.last_of_all, got.exhausted);
				return;
			end
			exp = expected_pairs.pop_front();
			bad = "";
			if (got.a_byte_offset !== exp.a_byte_offset) bad = {bad, " a_byte_offset"};
			if (got.b_byte_offset !== exp.b_byte_offset) bad = {bad, " b_byte_offset"};
			if (got.last_of_tile !== exp.last_of_tile)   bad = {bad, " last_of_tile"};
			if (got.last_of_all !== exp.last_of_all)     bad = {bad, " last_of_all"};
			if (got.exhausted !== exp.exhausted)         bad = {bad, " exhausted"};
			if (bad == "")
				return;
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("%0t: wrong%s: expected a %h b %h lt %b la %b ex %b, got a %h b %h lt %b la %b ex %b",
					$realtime, bad, exp.a_byte_offset, exp.b_byte_offset, exp.last_of_tile,
					exp.last_of_all, exp.exhausted, got.a_byte_offset, got.b_byte_offset,
					got.last_of_tile, got.last_of_all, got.exhausted);
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cmd_valid;
	logic                          cmd_ready;
	mtrag_pkg::cmd_t               cmd;
	logic                          pair_valid;
	logic                          pair_ready;
	mtrag_pkg::pair_t              pair;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [mtrag_pkg::ADDR_W-1:0]  paddr;
	logic [mtrag_pkg::DATA_W-1:0]  pwdata;
	logic [mtrag_pkg::DATA_W-1:0]  prdata;
	logic                          pready;

	read_pair_scoreboard sb = new();
	int unsigned         burst_left;

	matmul_tile_read_address_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pair_valid(pair_valid),
		.pair_ready(pair_ready),
		.pair      (pair),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("matmul_tile_read_address_generator: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && cmd_valid && cmd_ready)
			sb.note_word(cmd);
	end

	always @(posedge clk) begin
		if (arst_n && pair_valid && pair_ready)
			sb.check_pair(pair);
	end

	// Receiver: switches at random between stall patterns, holding each for a random span.
	initial begin
		int unsigned mode;
		int unsigned span;
		int unsigned run;
		bit          level;
		mode  = RX_ALWAYS;
		span  = 0;
		run   = 0;
		level = 1'b1;
		pair_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = $urandom_range(RX_ALWAYS, RX_RUNS);
				span = $urandom_range(50, 400);
			end
			span--;
			case (mode)
				RX_ALWAYS:   pair_ready <= 1'b1;
				RX_ONE_IN_4: pair_ready <= (span % 4) != 0;
				RX_COIN:     pair_ready <= 1'($urandom_range(0, 1));
				default: begin
					if (run == 0) begin
						level = ~level;
						run   = level ? $urandom_range(1, 20) : $urandom_range(1, 30);
					end
					run--;
					pair_ready <= level;
				end
			endcase
		end
	end

	task automatic send_word(input mtrag_pkg::cmd_t w);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		cmd_valid <= 1'b1;
		cmd       <= w;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic send_start(input logic [31:0] first, input logic [23:0] count);
		mtrag_pkg::cmd_t w;
		w.opcode     = mtrag_pkg::OP_START;
		w.start_tile = first;
		w.tile_count = count;
		send_word(w);
	endtask

	// Fields other than the opcode are ignored by a step, so they carry noise.
	task automatic send_step();
		mtrag_pkg::cmd_t w;
		w.opcode     = mtrag_pkg::OP_STEP;
		w.start_tile = $urandom();
		w.tile_count = 24'($urandom());
		send_word(w);
	endtask

	// A start produces no pair, so a finished pair stream does not mean the
	// block is done; the settle time covers a start still in progress.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_register(idx, value);
	endtask

	function automatic logic [31:0] grid_value(int unsigned kind);
		case (kind)
			CFG_LARGEST: return 32'h0000_FFFF;
			CFG_ZERO:    return 32'd0;
			CFG_TINY:    return $urandom_range(1, 4);
			CFG_WIDE:    return $urandom_range(1, 300);
			CFG_RAW:     return $urandom();
			default:     return $urandom_range(0, 4);
		endcase
	endfunction

	task automatic program_grid(input int unsigned kind);
		logic [31:0] bcast_word;
		write_reg(mtrag_pkg::REG_ROWS, grid_value(kind));
		write_reg(mtrag_pkg::REG_INNER, grid_value(kind));
		write_reg(mtrag_pkg::REG_COLS, grid_value(kind));
		if (kind == CFG_LARGEST)
			bcast_word = 32'd1;
		else if (kind == CFG_RAW)
			bcast_word = $urandom();
		else
			bcast_word = $urandom_range(0, 1);
		write_reg(mtrag_pkg::REG_BCAST, bcast_word);
	endtask

	task automatic send_random_start(output logic [23:0] count);
		logic [31:0] first;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			first = $urandom_range(0, 64);
		else if (pick < 8)
			first = $urandom();
		else
			first = 32'hFFFF_FFFF - $urandom_range(0, 64);
		pick = $urandom_range(0, 9);
		if (pick < 8)
			count = 24'($urandom_range(0, 6));
		else if (pick == 8)
			count = '0;
		else
			count = 24'($urandom());
		send_start(first, count);
	endtask

	// Mostly a start followed by enough steps to run it dry; sometimes steps
	// that carry on the previous run, and some raw noise words.
	task automatic run_phase(input int unsigned quota);
		int unsigned      sent;
		longint unsigned  steps;
		logic [23:0]      count;
		mtrag_pkg::cmd_t  w;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 5) != 0) begin
					send_random_start(count);
					sent++;
					steps = longint'(count) * sb.inner_tiles() + $urandom_range(0, 2);
					if (steps > 48)
						steps = $urandom_range(20, 48);
				end else begin
					steps = $urandom_range(1, 12);
				end
				repeat (steps) begin
					send_step();
					sent++;
				end
			end else begin
				w.opcode     = 1'($urandom_range(0, 1));
				w.start_tile = $urandom();
				w.tile_count = 24'($urandom());
				send_word(w);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		cmd_valid  <= 1'b0;
		cmd        <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		burst_left  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset grid: exhaustion, empty start, top start index.
		send_step();
		send_start(32'd0, 24'd0);
		send_step();
		send_start(32'hFFFF_FFFF, 24'd2);
		repeat (3) send_step();
		send_start(32'h8000_0000, 24'hFF_FFFF);
		repeat (2) send_step();
		wait_idle();

		// Small grid with B shared: column, matrix and batch wraps.
		write_reg(mtrag_pkg::REG_ROWS, 32'd2);
		write_reg(mtrag_pkg::REG_INNER, 32'd3);
		write_reg(mtrag_pkg::REG_COLS, 32'd2);
		write_reg(mtrag_pkg::REG_BCAST, 32'd1);
		send_start(32'd1, 24'd3);
		repeat (10) send_step();
		wait_idle();

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			if (phase < 2)
				program_grid(phase == 0 ? CFG_LARGEST : CFG_ZERO);
			else
				program_grid($urandom_range(CFG_TINY, CFG_MIXED));
			run_phase(PHASE_WORDS);
			wait_idle();
		end

		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("matmul_tile_read_address_generator: match");
		else
			$display("matmul_tile_read_address_generator: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mtrag_pkg.sv
sv/mtrag_div.sv
sv/matmul_tile_read_address_generator.sv
verif/matmul_tile_read_address_generator_tb.sv
